### hdl/gbc_pkg.sv
// shared types, constants and helpers of the 3x3 gaussian blur unit
package gbc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIX_BITS   = 8;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int W_BITS     = 11;
    localparam int H_BITS     = 13;
    localparam int CFG_BITS   = 13;
    localparam int CSUM_BITS  = PIX_BITS + 2;
    localparam int BLUR_BITS  = PIX_BITS + 4;
    localparam int LINE_BITS  = 2 * PIX_BITS;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req_e;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx_e;

    // one window column, top row first
    typedef struct packed {
        logic [PIX_BITS-1:0] top;
        logic [PIX_BITS-1:0] mid;
        logic [PIX_BITS-1:0] bot;
    } t_col;

    // control that travels with a word from the read stage to the compute stage
    typedef struct packed {
        logic                col0;
        logic                use_older;
        logic                is_pix;
        logic                out_en;
        logic                eof;
        logic [COL_BITS-1:0] addr;
        logic [PIX_BITS-1:0] pix;
    } t_s1_ctl;

    function automatic logic [CSUM_BITS-1:0] col_sum(input t_col c);
        col_sum = CSUM_BITS'(c.top) + {1'b0, c.mid, 1'b0} + CSUM_BITS'(c.bot);
    endfunction

endpackage

### hdl/gbc_line_ram.sv
// simple dual port line store, one write and one registered read per cycle
module gbc_line_ram #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 16,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

### hdl/gaussian_blur_3x3_clamp_edge_unit.sv
// top level of the streaming 3x3 gaussian blur with clamp-to-border edges
//
// Takes one word per clock (a pixel in row-major order or a drain word) and
// returns the 1-2-1 / 2-4-2 / 1-2-1 weighted sum as unsigned 8.4 fixed point.
// Sustained rate is one word per clock while the output side keeps taking
// results; the limit is the single line store port pair, which is read at the
// column of each new word and written back as that word leaves the compute
// stage. A result comes out for the pixel that lies image_width+1 words
// behind the current one, so after the last pixel of a frame, image_width+1
// drain words flush the last row. Drain words sent while pixels are still
// expected are dropped, pixels sent after the frame is complete count as drain
// words. After the result flagged end_of_frame the next word starts a new
// frame. Writing either register restarts the frame; width is taken mod 2048,
// then 0 acts as 1 and above 1024 as 1024, height 0 acts as 1 and height
// above 4096 as 4096. The line store is not cleared after reset and needs no
// clearing pass: every entry is written in the frame before it is used.
module gaussian_blur_3x3_clamp_edge_unit
    import gbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [CFG_BITS-1:0]  i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_req_type,
    input  logic [PIX_BITS-1:0]  i_pixel,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BLUR_BITS-1:0] o_blurred,
    output logic                 o_end_of_row,
    output logic                 o_end_of_frame
);

    // effective frame size and position of the next word
    logic [W_BITS-1:0]   r_width;
    logic [H_BITS-1:0]   r_height;
    logic [COL_BITS-1:0] r_col;
    logic [H_BITS-1:0]   r_row;
    logic                r_run;

    // compute stage
    logic                r_s1_valid;
    t_s1_ctl             r_s1;
    logic                r_fwd;
    logic [LINE_BITS-1:0] r_fwd_data;
    t_col                r_win [3];

    // output register
    logic                 r_out_valid;
    logic [BLUR_BITS-1:0] r_blurred;
    logic                 r_eor;
    logic                 r_eof;

    logic                 in_fire;
    logic                 s1_fire;
    logic                 is_pix;
    logic                 ignore;
    logic                 issue;
    logic                 last_col;
    logic                 frame_end;
    logic [W_BITS-1:0]    col_inc;
    logic [W_BITS-1:0]    cfg_w;
    logic [H_BITS-1:0]    cfg_h;
    t_s1_ctl              s1_ctl;

    logic [LINE_BITS-1:0] ram_q;
    logic [LINE_BITS-1:0] line_word;
    logic [PIX_BITS-1:0]  older;
    logic [PIX_BITS-1:0]  newer;
    logic                 ram_we;
    logic [LINE_BITS-1:0] ram_wdata;
    t_col                 new_col;
    logic [CSUM_BITS-1:0] cs1;
    logic [CSUM_BITS-1:0] cs2;
    logic [CSUM_BITS-1:0] cs_new;
    logic [BLUR_BITS-1:0] blur_edge;
    logic [BLUR_BITS-1:0] blur_mid;

    // ---------------------------------------------------------------------
    // handshake and read stage
    // ---------------------------------------------------------------------
    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = r_run && (!r_s1_valid || s1_fire);
    assign in_fire    = i_in_valid && o_in_ready;

    // pixels are expected while the row count is inside the frame
    assign is_pix   = (r_row < r_height);
    assign ignore   = is_pix && (i_req_type == REQ_DRAIN);
    assign issue    = in_fire && !ignore;

    assign col_inc   = W_BITS'(r_col) + W_BITS'(1);
    assign last_col  = (col_inc == r_width);
    // final output of the frame leaves on column zero two rows below the last
    assign frame_end = (r_col == '0) && (r_row == r_height + H_BITS'(1));

    // clamp register values to the supported range
    always_comb begin
        cfg_w = i_cfg_data[W_BITS-1:0];
        if (cfg_w == '0) begin
            cfg_w = W_BITS'(1);
        end else if (cfg_w > W_BITS'(MAX_WIDTH)) begin
            cfg_w = W_BITS'(MAX_WIDTH);
        end
        cfg_h = i_cfg_data[H_BITS-1:0];
        if (cfg_h == '0) begin
            cfg_h = H_BITS'(1);
        end else if (cfg_h > H_BITS'(MAX_HEIGHT)) begin
            cfg_h = H_BITS'(MAX_HEIGHT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= W_BITS'(MAX_WIDTH);
            r_height <= H_BITS'(1024);
            r_col    <= '0;
            r_row    <= '0;
            r_run    <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                unique case (t_cfg_idx_e'(i_cfg_index))
                    CFG_IMAGE_WIDTH:  r_width  <= cfg_w;
                    CFG_IMAGE_HEIGHT: r_height <= cfg_h;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (issue) begin
                if (frame_end) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + H_BITS'(1);
                end else begin
                    r_col <= r_col + COL_BITS'(1);
                end
            end
        end
    end

    // control carried to the compute stage
    always_comb begin
        s1_ctl.col0      = (r_col == '0);
        s1_ctl.use_older = (r_row >= H_BITS'(2));
        s1_ctl.is_pix    = is_pix;
        s1_ctl.out_en    = (r_row >= H_BITS'(2)) ||
                           ((r_row == H_BITS'(1)) && (r_col != '0));
        s1_ctl.eof       = frame_end;
        s1_ctl.addr      = r_col;
        s1_ctl.pix       = i_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (issue) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // forward the write-back when the next word reads the same column
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1       <= s1_ctl;
            r_fwd      <= ram_we && (r_s1.addr == r_col);
            r_fwd_data <= ram_wdata;
        end
    end

    // ---------------------------------------------------------------------
    // line store: older row in the upper byte, newer row in the lower byte
    // ---------------------------------------------------------------------
    gbc_line_ram #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (LINE_BITS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.addr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    assign line_word = r_fwd ? r_fwd_data : ram_q;
    assign older     = line_word[LINE_BITS-1:PIX_BITS];
    assign newer     = line_word[PIX_BITS-1:0];

    // pixel shifts the column up by one row
    assign ram_we    = s1_fire && r_s1.is_pix;
    assign ram_wdata = {newer, r_s1.pix};

    // ---------------------------------------------------------------------
    // compute stage: window update and weighted sum
    // ---------------------------------------------------------------------
    always_comb begin
        new_col.mid = newer;
        new_col.top = r_s1.use_older ? older : newer;
        new_col.bot = r_s1.is_pix ? r_s1.pix : newer;
    end

    assign cs1    = col_sum(r_win[1]);
    assign cs2    = col_sum(r_win[2]);
    assign cs_new = col_sum(new_col);

    // row end: right neighbour clamps onto the last column
    assign blur_edge = BLUR_BITS'(cs1) + BLUR_BITS'(cs2) + {1'b0, cs2, 1'b0};
    assign blur_mid  = BLUR_BITS'(cs1) + {1'b0, cs2, 1'b0} + BLUR_BITS'(cs_new);

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            if (r_s1.col0) begin
                r_win[0] <= new_col;
                r_win[1] <= new_col;
                r_win[2] <= new_col;
            end else begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= new_col;
            end
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1.out_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.out_en) begin
            r_blurred <= r_s1.col0 ? blur_edge : blur_mid;
            r_eor     <= r_s1.col0;
            r_eof     <= r_s1.eof;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_blurred      = r_blurred;
    assign o_end_of_row   = r_eor;
    assign o_end_of_frame = r_eof;

endmodule

### hdl/gbc_checker.sv
// port level checks of the gaussian blur unit and their binding
module gbc_checker
    import gbc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [BLUR_BITS-1:0] o_blurred,
    input logic                 o_end_of_row,
    input logic                 o_end_of_frame
);

    // a stalled result word keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_blurred))
        else $error("stalled result word changed");

    // frame end always closes a row
    a_eof_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_end_of_row)
        else $error("end of frame without end of row");

    // weighted sum of 8-bit pixels never exceeds 16 * 255
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_blurred <= BLUR_BITS'(4080)))
        else $error("blurred value out of range");

    // nothing moves in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("handshake active right after reset");

endmodule

bind gaussian_blur_3x3_clamp_edge_unit gbc_checker u_gbc_checker (.*);

### verif/gaussian_blur_3x3_clamp_edge_unit_test.sv
// self-checking testbench for the streaming 3x3 gaussian blur unit with clamped edges
module gaussian_blur_3x3_clamp_edge_unit_test;
    import gbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int SETTLE_CYCLES  = 16;     // idle time before a register write
    localparam int TAIL_CYCLES    = 40;     // extra cycles after the last result
    localparam int HOLD_CYCLES    = 1200;   // the one long receiver hold-off
    localparam int WATCHDOG_LIMIT = 10000;  // cycles with no word moving on either side
    localparam int RANDOM_WORDS   = 1150;
    localparam int MAX_REPORTS    = 100;

    // what the sender queue can hold besides plain words
    typedef enum logic [1:0] {
        ACT_WORD,
        ACT_CFG,
        ACT_SYNC,   // sender waits until every expected result is out
        ACT_HOLD    // receiver starts its long hold-off
    } t_act_e;

    typedef enum logic [2:0] {
        STYLE_NOISE,
        STYLE_BLACK,
        STYLE_WHITE,
        STYLE_CHECKER,
        STYLE_RAMP,
        STYLE_SPIKES
    } t_style_e;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode_e;

    typedef struct packed {
        t_act_e              act;
        t_req_e              kind;
        logic [PIX_BITS-1:0] pix;
        t_cfg_idx_e          idx;
        logic [CFG_BITS-1:0] data;
    } t_pending;

    typedef struct packed {
        logic [BLUR_BITS-1:0] blurred;
        logic                 end_of_row;
        logic                 end_of_frame;
    } t_blur_px;

    // dut connections, the inputs all known from time zero
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    t_cfg_idx_e           i_cfg_index    = CFG_IMAGE_WIDTH;
    logic [CFG_BITS-1:0]  i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    t_req_e               i_req_type     = REQ_PIXEL;
    logic [PIX_BITS-1:0]  i_pixel        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic [BLUR_BITS-1:0] o_blurred;
    logic                 o_end_of_row;
    logic                 o_end_of_frame;

    // stimulus and scoreboard
    t_pending    stream_queue [$];
    t_blur_px    pending_blurs [$];
    int unsigned fail_count    = 0;
    int unsigned live_words    = 0;   // words that move the frame along
    logic        in_taken      = 1'b0;
    logic        sender_done   = 1'b0;
    logic        hold_req      = 1'b0;
    logic        watchdog_hit  = 1'b0;
    int unsigned stall_cycles  = 0;

    // generator's view of the frame size (effective values)
    int unsigned frame_w = MAX_WIDTH;
    int unsigned frame_h = 1024;

    // blur predictor state
    logic [W_BITS-1:0]   img_w_reg = 11'd1024;
    logic [H_BITS-1:0]   img_h_reg = 13'd1024;
    logic [PIX_BITS-1:0] older_row [MAX_WIDTH] = '{default: '0};
    logic [PIX_BITS-1:0] newer_row [MAX_WIDTH] = '{default: '0};
    t_col                win [3] = '{default: '0};   // index 0 is the oldest column
    int unsigned         col_pos  = 0;
    int unsigned         row_pos  = 0;
    int unsigned         word_pos = 0;

    gaussian_blur_3x3_clamp_edge_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_pixel        (i_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_blurred      (o_blurred),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // blur predictor
    // ------------------------------------------------------------------

    // zero acts as one, anything past the top acts as the top
    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic int unsigned col_weight(input t_col c);
        return c.top + 2 * c.mid + c.bot;
    endfunction

    // 1-2-1 across columns on top of 1-2-1 down each column
    function automatic logic [BLUR_BITS-1:0] weigh(input t_col l, input t_col m, input t_col r);
        return BLUR_BITS'(col_weight(l) + 2 * col_weight(m) + col_weight(r));
    endfunction

    task automatic restart_frame();
        win      = '{default: '0};
        col_pos  = 0;
        row_pos  = 0;
        word_pos = 0;
    endtask

    task automatic apply_cfg(input t_cfg_idx_e idx, input logic [CFG_BITS-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:  img_w_reg = data[W_BITS-1:0];
            CFG_IMAGE_HEIGHT: img_h_reg = data[H_BITS-1:0];
        endcase
        restart_frame();
    endtask

    // one accepted word: advance the window and line stores, queue what comes out
    task automatic compute_blur(input t_req_e kind, input logic [PIX_BITS-1:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned r;
        int unsigned total;
        int unsigned lag;
        logic        is_pix;
        logic        eof_hit;
        t_col        fresh;
        t_blur_px    px;
        w       = clamp_size(img_w_reg, MAX_WIDTH);
        h       = clamp_size(img_h_reg, MAX_HEIGHT);
        x       = col_pos;
        r       = row_pos;
        total   = w * h;
        lag     = w + 1;
        is_pix  = (r < h);
        eof_hit = 1'b0;
        // drain word while pixels are still due: dropped
        if (is_pix && kind == REQ_DRAIN) return;
        if (x >= w) x = w - 1;

        // new row starts: the previous output row closes with its right edge clamped
        if (x == 0 && word_pos >= lag && word_pos - lag < total) begin
            eof_hit         = (word_pos - lag == total - 1);
            px.blurred      = weigh(win[1], win[2], win[2]);
            px.end_of_row   = 1'b1;
            px.end_of_frame = eof_hit;
            pending_blurs.push_back(px);
        end

        // rows above come from the line stores, clamped at the top and bottom
        fresh.mid = newer_row[x];
        fresh.top = (r >= 2) ? older_row[x] : fresh.mid;
        fresh.bot = is_pix ? pix : fresh.mid;

        if (x == 0) begin
            // left edge clamp: every column starts as the first one
            win = '{fresh, fresh, fresh};
        end else begin
            win[0] = win[1];
            win[1] = win[2];
            win[2] = fresh;
            if (word_pos >= lag && word_pos - lag < total) begin
                px.blurred      = weigh(win[0], win[1], win[2]);
                px.end_of_row   = 1'b0;
                px.end_of_frame = 1'b0;
                pending_blurs.push_back(px);
            end
        end

        if (is_pix) begin
            older_row[x] = newer_row[x];
            newer_row[x] = pix;
        end

        if (eof_hit) begin
            restart_frame();
            return;
        end

        word_pos = (word_pos + 1) & 32'h7F_FFFF;
        x++;
        if (x >= w) begin
            x = 0;
            r = (r + 1) & 32'h1FFF;
        end
        col_pos = x;
        row_pos = r;
    endtask

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------

    task automatic queue_word(input t_req_e kind, input logic [PIX_BITS-1:0] pix);
        t_pending p;
        p      = '0;
        p.act  = ACT_WORD;
        p.kind = kind;
        p.pix  = pix;
        stream_queue.push_back(p);
    endtask

    task automatic queue_cfg(input t_cfg_idx_e idx, input logic [CFG_BITS-1:0] data);
        t_pending p;
        p      = '0;
        p.act  = ACT_CFG;
        p.idx  = idx;
        p.data = data;
        stream_queue.push_back(p);
        if (idx == CFG_IMAGE_WIDTH)
            frame_w = clamp_size(data[W_BITS-1:0], MAX_WIDTH);
        else
            frame_h = clamp_size(data[H_BITS-1:0], MAX_HEIGHT);
    endtask

    task automatic queue_marker(input t_act_e act);
        t_pending p;
        p     = '0;
        p.act = act;
        stream_queue.push_back(p);
    endtask

    function automatic logic [PIX_BITS-1:0] pixel_for(input t_style_e style,
                                                      input int unsigned x,
                                                      input int unsigned y);
        case (style)
            STYLE_BLACK:   return '0;
            STYLE_WHITE:   return '1;
            STYLE_CHECKER: return ((x ^ y) & 1) ? '1 : '0;
            STYLE_RAMP:    return PIX_BITS'(x * 37 + y * 11);
            STYLE_SPIKES: begin
                case ($urandom_range(2))
                    0:       return '0;
                    1:       return '1;
                    default: return PIX_BITS'($urandom);
                endcase
            end
            default:       return PIX_BITS'($urandom);
        endcase
    endfunction

    // a frame of the current size: pixels with stray drain words mixed in, then the
    // flush; a cut frame stops after a random number of pixels and gets no flush
    task automatic queue_frame(input t_style_e style, input int unsigned noise_pct,
                               input bit cut, input bit pause_inside);
        int unsigned total;
        int unsigned stop_at;
        int unsigned pause_at;
        total    = frame_w * frame_h;
        stop_at  = cut ? $urandom_range(1, total) : total;
        pause_at = $urandom_range(0, total - 1);
        for (int unsigned i = 0; i < stop_at; i++) begin
            if ($urandom_range(99) < noise_pct)
                queue_word(REQ_DRAIN, PIX_BITS'($urandom));
            if (pause_inside && i == pause_at)
                queue_marker(ACT_SYNC);
            queue_word(REQ_PIXEL, pixel_for(style, i % frame_w, i / frame_w));
        end
        live_words += stop_at;
        if (cut) return;
        // flush: pixel words here count as drain words
        for (int unsigned j = 0; j <= frame_w; j++) begin
            if ($urandom_range(3) == 0)
                queue_word(REQ_PIXEL, PIX_BITS'($urandom));
            else
                queue_word(REQ_DRAIN, PIX_BITS'($urandom));
        end
        live_words += frame_w + 1;
        // stray drain after the frame end falls into the next frame and is dropped
        if ($urandom_range(3) == 0)
            queue_word(REQ_DRAIN, PIX_BITS'($urandom));
    endtask

    // ------------------------------------------------------------------
    // driver: one word or register write per decision, changes on the falling edge
    // ------------------------------------------------------------------
    int unsigned burst_left = 8;
    int unsigned gap_left   = 0;
    int unsigned quiet      = 0;

    always @(negedge i_clk) begin : driver
        logic     valid_nxt;
        logic     cfg_we_nxt;
        t_pending head;
        valid_nxt  = i_in_valid && !in_taken;
        cfg_we_nxt = 1'b0;
        if (i_rst_n && !valid_nxt) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (stream_queue.size() != 0) begin
                head = stream_queue[0];
                case (head.act)
                    ACT_WORD: begin
                        head       = stream_queue.pop_front();
                        valid_nxt  = 1'b1;
                        i_req_type <= head.kind;
                        i_pixel    <= head.pix;
                        // bursts of random length, gaps often zero
                        if (burst_left > 1) begin
                            burst_left--;
                        end else begin
                            burst_left = $urandom_range(1, 48);
                            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                    ACT_CFG: begin
                        // only once the block has had time to go fully idle
                        if (pending_blurs.size() == 0 && quiet >= SETTLE_CYCLES) begin
                            head        = stream_queue.pop_front();
                            cfg_we_nxt  = 1'b1;
                            i_cfg_index <= head.idx;
                            i_cfg_data  <= head.data;
                            apply_cfg(head.idx, head.data);
                        end
                    end
                    ACT_SYNC: begin
                        if (pending_blurs.size() == 0)
                            head = stream_queue.pop_front();
                    end
                    ACT_HOLD: begin
                        hold_req = 1'b1;
                        head     = stream_queue.pop_front();
                    end
                endcase
            end
        end
        sender_done = (stream_queue.size() == 0) && !valid_nxt;
        // idle time counts only with nothing in flight on either side
        if (pending_blurs.size() != 0 || i_in_valid || i_cfg_we)
            quiet = 0;
        else if (quiet < SETTLE_CYCLES)
            quiet++;
        i_in_valid <= valid_nxt;
        i_cfg_we   <= cfg_we_nxt;
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern changes per segment, plus one long hold-off
    // ------------------------------------------------------------------
    t_rx_mode_e  rx_mode     = RX_FREE;
    int unsigned rx_seg_left = 0;
    int unsigned rx_phase    = 0;
    int unsigned hold_left   = 0;
    logic        hold_seen   = 1'b0;

    always @(negedge i_clk) begin : receiver
        logic ready_nxt;
        if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            ready_nxt = 1'b0;
        end else begin
            if (rx_seg_left == 0) begin
                rx_mode     = t_rx_mode_e'($urandom_range(3));
                rx_seg_left = $urandom_range(16, 200);
            end
            rx_seg_left--;
            rx_phase++;
            case (rx_mode)
                RX_FREE:   ready_nxt = 1'b1;
                RX_COIN:   ready_nxt = ($urandom_range(1) == 1);
                RX_SPARSE: ready_nxt = ($urandom_range(3) == 0);
                default:   ready_nxt = (rx_phase % 7) < 3;
            endcase
        end
        i_out_ready <= ready_nxt;
    end

    // ------------------------------------------------------------------
    // monitor: sample both handshakes at the rising edge, check then predict
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string field, input logic [BLUR_BITS-1:0] want_v,
                                 input logic [BLUR_BITS-1:0] got_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : monitor
        logic     out_taken;
        t_blur_px want;
        in_taken  = i_rst_n && i_in_valid && o_in_ready;
        out_taken = i_rst_n && o_out_valid && i_out_ready;
        // output first: a word taken at this edge cannot show up at this edge
        if (out_taken) begin
            if (pending_blurs.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("unexpected result: blurred %0d end_of_row %0b end_of_frame %0b",
                           o_blurred, o_end_of_row, o_end_of_frame);
            end else begin
                want = pending_blurs.pop_front();
                if (o_blurred !== want.blurred)
                    note_mismatch("blurred", want.blurred, o_blurred);
                if (o_end_of_row !== want.end_of_row)
                    note_mismatch("end_of_row", want.end_of_row, o_end_of_row);
                if (o_end_of_frame !== want.end_of_frame)
                    note_mismatch("end_of_frame", want.end_of_frame, o_end_of_frame);
            end
        end
        if (in_taken)
            compute_blur(i_req_type, i_pixel);
        // watchdog: nothing moved on either side for too long
        if (in_taken || out_taken)
            stall_cycles = 0;
        else if (stall_cycles < WATCHDOG_LIMIT)
            stall_cycles++;
        else
            watchdog_hit = 1'b1;
    end

    // ------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [CFG_BITS-1:0] wdata;
        logic [CFG_BITS-1:0] hdata;
        int unsigned         pick;
        bit                  was_cut;
        bit                  cut_now;
        was_cut = 1'b0;

        // zero sizes: one-pixel frame, stray drain before it, pixel word in the flush
        queue_cfg(CFG_IMAGE_WIDTH, '0);
        queue_cfg(CFG_IMAGE_HEIGHT, '0);
        queue_word(REQ_DRAIN, 8'h5A);
        queue_word(REQ_PIXEL, '1);
        queue_word(REQ_PIXEL, '0);
        queue_word(REQ_DRAIN, '1);
        queue_word(REQ_DRAIN, 8'h11);

        // 3x2 vertical stripes of the pixel extremes with a drain inside the frame
        queue_cfg(CFG_IMAGE_WIDTH, 13'd3);
        queue_cfg(CFG_IMAGE_HEIGHT, 13'd2);
        for (int i = 0; i < 6; i++) begin
            if (i == 2)
                queue_word(REQ_DRAIN, 8'hC3);
            queue_word(REQ_PIXEL, ((i + i / 3) % 2) ? '1 : '0);
        end
        queue_word(REQ_DRAIN, '0);
        queue_word(REQ_PIXEL, 8'hAA);
        queue_word(REQ_DRAIN, '1);
        queue_word(REQ_PIXEL, 8'h55);

        // next frame straight after the frame end, no register write
        for (int i = 0; i < 6; i++)
            queue_word(REQ_PIXEL, '1);
        for (int i = 0; i < 4; i++)
            queue_word(REQ_DRAIN, '0);

        // back-pressure: long receiver hold-off while a tall frame keeps coming,
        // with a pause inside it until everything expected has drained
        queue_cfg(CFG_IMAGE_WIDTH, 13'd16);
        queue_cfg(CFG_IMAGE_HEIGHT, 13'd40);
        queue_marker(ACT_HOLD);
        queue_frame(STYLE_NOISE, 5, 1'b0, 1'b1);

        // random frames, mostly small and well formed
        live_words = 0;
        while (live_words < RANDOM_WORDS) begin
            if (was_cut || $urandom_range(99) < 70) begin
                pick = $urandom_range(2);   // width only, height only, or both
                if (pick != 1) begin
                    case ($urandom_range(9))
                        0:       wdata = '0;
                        7, 8:    wdata = CFG_BITS'($urandom_range(9, 40));
                        default: wdata = CFG_BITS'($urandom_range(1, 8));
                    endcase
                    // bits above the width register are dropped
                    if ($urandom_range(3) == 0)
                        wdata = wdata | (CFG_BITS'($urandom_range(1, 3)) << W_BITS);
                    queue_cfg(CFG_IMAGE_WIDTH, wdata);
                end
                if (pick != 0) begin
                    case ($urandom_range(9))
                        0:       hdata = '0;
                        8:       hdata = CFG_BITS'($urandom_range(9, 16));
                        default: hdata = CFG_BITS'($urandom_range(1, 8));
                    endcase
                    queue_cfg(CFG_IMAGE_HEIGHT, hdata);
                end
            end
            cut_now = ($urandom_range(99) < 8);
            queue_frame(t_style_e'($urandom_range(5)),
                        ($urandom_range(3) == 0) ? $urandom_range(5, 30) : 0,
                        cut_now, ($urandom_range(9) == 0));
            was_cut = cut_now;
        end

        // synchronous reset, released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent and everything expected received, or the watchdog fired
        while (!((sender_done && pending_blurs.size() == 0) || watchdog_hit))
            @(negedge i_clk);
        if (!watchdog_hit)
            repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_blurs.size() != 0)
            $error("%0d expected results never arrived", pending_blurs.size());
        if (watchdog_hit || fail_count != 0 || pending_blurs.size() != 0)
            $display("CHECKS FAILED");
        else
            $display("ALL CHECKS PASSED");
        $finish;
    end

endmodule
